// File: src/mbet_pkg.sv
`default_nettype none

package mbet_pkg;

  // Geometry and number format
  localparam int unsigned MAX_PIXELS    = 4096;
  localparam int unsigned FRAC_BITS     = 24;
  localparam int unsigned COUNT_BITS    = 16;

  localparam int unsigned PIX_W         = 12;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned STEP_W        = 31;
  localparam int unsigned MAXIT_W       = 16;
  localparam int unsigned SHADE_W       = 8;
  localparam int unsigned SHADE_SHIFT   = 2;
  localparam int unsigned ESC_RADIUS    = 10;

  // Shared multiplier
  localparam int unsigned MUL_W         = 32;
  localparam int unsigned PROD_W        = 2 * MUL_W;

  // Iteration datapath: |x|,|y| <= 10 after a passed check, |z| < 2^8 after an update
  localparam int unsigned MAG_W         = FRAC_BITS + 4;
  localparam int unsigned SQ_W          = 2 * MAG_W;
  localparam int unsigned SUM_W         = SQ_W + 1;
  localparam int unsigned XY_W          = SQ_W + 2;
  localparam int unsigned Z_W           = FRAC_BITS + 10;

  // Point mapping
  localparam int unsigned CPROD_W       = PIX_W + STEP_W;
  localparam int unsigned CSUM_W        = CPROD_W + 2;

  localparam logic [Z_W-1:0]   ESC_LIM = Z_W'(ESC_RADIUS) << FRAC_BITS;
  localparam logic [SUM_W-1:0] ESC_THR = SUM_W'(ESC_RADIUS * ESC_RADIUS) << (2 * FRAC_BITS);

  // Register reset values
  localparam logic [COORD_W-1:0] LEFT_RST   = 32'hFE00_0000;
  localparam logic [COORD_W-1:0] TOP_RST    = 32'h0100_0000;
  localparam logic [STEP_W-1:0]  CSTEP_RST  = 31'd16384;
  localparam logic [STEP_W-1:0]  RSTEP_RST  = 31'd16384;
  localparam logic [MAXIT_W-1:0] MAXIT_RST  = 16'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_EDGE   = 3'd0,
    REG_TOP_EDGE    = 3'd1,
    REG_COLUMN_STEP = 3'd2,
    REG_ROW_STEP    = 3'd3,
    REG_MAX_ITER    = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MUL_COL,
    MUL_ROW,
    MUL_XY,
    MUL_XX,
    MUL_YY
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CX,
    ST_CY,
    ST_CFIN,
    ST_XY,
    ST_UPD,
    ST_XX,
    ST_YY,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic     in_ready;
    mul_sel_e mul_sel;
    logic     ld_cx;
    logic     ld_cy;
    logic     init_z;
    logic     cnt_inc;
    logic     ld_z;
    logic     ld_sqx;
    logic     ld_sqy;
    logic     finish;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic max_zero;
    logic esc_mag;
    logic esc_sum;
    logic cnt_at_max;
  } stat_t;

  // Clamp a pixel index to the last valid pixel
  function automatic logic [PIX_W-1:0] clamp_pix(input logic [PIX_W-1:0] p);
    logic [PIX_W-1:0] r;
    r = p;
    if (32'(p) >= MAX_PIXELS) begin
      r = PIX_W'(MAX_PIXELS - 1);
    end
    return r;
  endfunction

  // Saturate a mapped coordinate to the signed Q8.24 range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [CSUM_W-1:0] v);
    logic signed [CSUM_W-1:0] hi;
    logic signed [CSUM_W-1:0] lo;
    logic signed [COORD_W-1:0] r;
    hi = CSUM_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - CSUM_W'(1);
    if (v > hi) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < lo) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = COORD_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/mbet_pix_if.sv
`default_nettype none

interface mbet_pix_if
  import mbet_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_column;
  logic [PIX_W-1:0] pixel_row;

  modport source (output valid, output pixel_column, output pixel_row, input ready);
  modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

`default_nettype wire

// File: src/mbet_res_if.sv
`default_nettype none

interface mbet_res_if
  import mbet_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] iteration_count;
  logic [SHADE_W-1:0]    gray_shade;

  modport source (output valid, output iteration_count, output gray_shade, input ready);
  modport sink   (input valid, input iteration_count, input gray_shade, output ready);
endinterface

`default_nettype wire

// File: src/mbet_cfg_if.sv
`default_nettype none

interface mbet_cfg_if
  import mbet_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// File: src/mandelbrot_escape_time_pixel_unit.sv
// Channel  | Dir | Modport        | Word
// ---------+-----+----------------+------------------------------------------
// pix_i    | in  | mbet_pix_if    | pixel_column, pixel_row
// res_o    | out | mbet_res_if    | iteration_count, gray_shade
// cfg_i    | in  | mbet_cfg_if    | reg_index, wdata (always ready)
//
// Each pixel is worked through the single shared 32x32 multiplier: two mapping
// products per pixel, then three products per iteration. An iteration whose
// update escapes on magnitude alone skips the y*y product and the sum check,
// and a zero iteration bound skips the iterations altogether.
// One pixel is worked on at a time; pix_i is ready only while the sequencer is
// idle. A finished result sits in the output register, so the next pixel is
// taken while res_o stalls. rst_ni clears control state and loads the
// register defaults.
`default_nettype none

module mandelbrot_escape_time_pixel_unit
  import mbet_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mbet_pix_if.sink    pix_i,
  mbet_res_if.source  res_o,
  mbet_cfg_if.sink    cfg_i
);

  ctrl_t ctrl;
  stat_t stat;

  // Configuration registers
  logic signed [COORD_W-1:0] left_q;
  logic signed [COORD_W-1:0] top_q;
  logic        [STEP_W-1:0]  cstep_q;
  logic        [STEP_W-1:0]  rstep_q;
  logic        [MAXIT_W-1:0] maxit_q;

  // Pixel and point
  logic        [PIX_W-1:0]   col_q;
  logic        [PIX_W-1:0]   row_q;
  logic signed [COORD_W-1:0] cx_q;
  logic signed [COORD_W-1:0] cy_q;

  // Iteration state
  logic signed [Z_W-1:0]        x_q;
  logic signed [Z_W-1:0]        y_q;
  logic        [SQ_W-1:0]       sqx_q;
  logic        [SQ_W-1:0]       sqy_q;
  logic        [COUNT_BITS-1:0] count_q;

  // Output word
  logic                  out_valid_q;
  logic [COUNT_BITS-1:0] out_count_q;
  logic [SHADE_W-1:0]    out_shade_q;

  // Shared multiplier
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;

  logic                      in_fire;
  logic [Z_W-1:0]            mag_x;
  logic [Z_W-1:0]            mag_y;
  logic signed [CSUM_W-1:0]  cx_sum;
  logic signed [CSUM_W-1:0]  cy_sum;
  logic signed [SUM_W-1:0]   sq_diff;
  logic signed [SUM_W-1:0]   sq_diff_sh;
  logic signed [XY_W-1:0]    xy_w;
  logic signed [XY_W-1:0]    xy_s;
  logic signed [XY_W-1:0]    xy_sh;
  logic signed [Z_W-1:0]     nx;
  logic signed [Z_W-1:0]     ny;
  logic [SUM_W-1:0]          sq_sum;

  mbet_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  mbet_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign cfg_i.ready = 1'b1;
  assign pix_i.ready = ctrl.in_ready;
  assign in_fire     = pix_i.valid && ctrl.in_ready;

  // Write configuration registers; drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= LEFT_RST;
      top_q   <= TOP_RST;
      cstep_q <= CSTEP_RST;
      rstep_q <= RSTEP_RST;
      maxit_q <= MAXIT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        REG_LEFT_EDGE:   left_q  <= cfg_i.wdata;
        REG_TOP_EDGE:    top_q   <= cfg_i.wdata;
        REG_COLUMN_STEP: cstep_q <= cfg_i.wdata[STEP_W-1:0];
        REG_ROW_STEP:    rstep_q <= cfg_i.wdata[STEP_W-1:0];
        REG_MAX_ITER:    maxit_q <= cfg_i.wdata[MAXIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Magnitudes of the current z
  assign mag_x = x_q[Z_W-1] ? Z_W'(-x_q) : Z_W'(x_q);
  assign mag_y = y_q[Z_W-1] ? Z_W'(-y_q) : Z_W'(y_q);

  // Select multiplier operands
  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_COL: begin
        mul_a = MUL_W'(col_q);
        mul_b = MUL_W'(cstep_q);
      end
      MUL_ROW: begin
        mul_a = MUL_W'(row_q);
        mul_b = MUL_W'(rstep_q);
      end
      MUL_XY: begin
        mul_a = MUL_W'(mag_x[MAG_W-1:0]);
        mul_b = MUL_W'(mag_y[MAG_W-1:0]);
      end
      MUL_XX: begin
        mul_a = MUL_W'(mag_x[MAG_W-1:0]);
        mul_b = MUL_W'(mag_x[MAG_W-1:0]);
      end
      MUL_YY: begin
        mul_a = MUL_W'(mag_y[MAG_W-1:0]);
        mul_b = MUL_W'(mag_y[MAG_W-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Map pixel to point
  assign cx_sum = CSUM_W'(left_q) + $signed({2'b00, prod[CPROD_W-1:0]});
  assign cy_sum = CSUM_W'(top_q) - $signed({2'b00, prod[CPROD_W-1:0]});

  // z*z + c, floor on the fraction drop
  assign sq_diff    = $signed({1'b0, sqx_q}) - $signed({1'b0, sqy_q});
  assign sq_diff_sh = sq_diff >>> FRAC_BITS;
  assign nx         = Z_W'(sq_diff_sh) + Z_W'(cx_q);

  assign xy_w  = $signed({1'b0, prod[SQ_W-1:0], 1'b0});
  assign xy_s  = (x_q[Z_W-1] ^ y_q[Z_W-1]) ? -xy_w : xy_w;
  assign xy_sh = xy_s >>> FRAC_BITS;
  assign ny    = Z_W'(xy_sh) + Z_W'(cy_q);

  assign sq_sum = SUM_W'(sqx_q) + SUM_W'(prod[SQ_W-1:0]);

  // Status to the sequencer
  always_comb begin
    stat.in_valid   = pix_i.valid;
    stat.out_free   = !out_valid_q || res_o.ready;
    stat.max_zero   = (maxit_q == '0);
    stat.esc_mag    = (mag_x > ESC_LIM) || (mag_y > ESC_LIM);
    stat.esc_sum    = (sq_sum > ESC_THR);
    stat.cnt_at_max = (count_q == COUNT_BITS'(maxit_q));
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      col_q <= clamp_pix(pix_i.pixel_column);
      row_q <= clamp_pix(pix_i.pixel_row);
    end
    if (ctrl.ld_cx) begin
      cx_q <= sat_coord(cx_sum);
    end
    if (ctrl.ld_cy) begin
      cy_q <= sat_coord(cy_sum);
    end
    if (ctrl.init_z) begin
      x_q     <= '0;
      y_q     <= '0;
      sqx_q   <= '0;
      sqy_q   <= '0;
      count_q <= '0;
    end else begin
      if (ctrl.cnt_inc) begin
        count_q <= count_q + COUNT_BITS'(1);
      end
      if (ctrl.ld_z) begin
        x_q <= nx;
        y_q <= ny;
      end
      if (ctrl.ld_sqx) begin
        sqx_q <= prod[SQ_W-1:0];
      end
      if (ctrl.ld_sqy) begin
        sqy_q <= prod[SQ_W-1:0];
      end
    end
    if (ctrl.finish) begin
      out_count_q <= count_q;
      out_shade_q <= SHADE_W'(count_q << SHADE_SHIFT);
    end
  end

  // Output word valid: set on finish, clear when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.iteration_count = out_count_q;
  assign res_o.gray_shade      = out_shade_q;

endmodule

`default_nettype wire

// File: src/mbet_mul.sv
`default_nettype none

module mbet_mul
  import mbet_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [MUL_W-1:0]  a_i,
  input  wire logic [MUL_W-1:0]  b_i,
  output logic      [PROD_W-1:0] prod_o
);

  // Register the unsigned product
  always_ff @(posedge clk_i) begin
    prod_o <= a_i * b_i;
  end

endmodule

`default_nettype wire

// File: src/mbet_ctrl.sv
`default_nettype none

module mbet_ctrl
  import mbet_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and control word
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.mul_sel = MUL_COL;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          state_d = ST_CX;
        end
      end
      ST_CX: begin
        ctrl_o.mul_sel = MUL_COL;
        state_d = ST_CY;
      end
      ST_CY: begin
        ctrl_o.mul_sel = MUL_ROW;
        ctrl_o.ld_cx   = 1'b1;
        state_d = ST_CFIN;
      end
      ST_CFIN: begin
        ctrl_o.ld_cy  = 1'b1;
        ctrl_o.init_z = 1'b1;
        state_d = stat_i.max_zero ? ST_DONE : ST_XY;
      end
      ST_XY: begin
        ctrl_o.mul_sel = MUL_XY;
        ctrl_o.cnt_inc = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        ctrl_o.ld_z = 1'b1;
        state_d = ST_XX;
      end
      ST_XX: begin
        ctrl_o.mul_sel = MUL_XX;
        state_d = stat_i.esc_mag ? ST_DONE : ST_YY;
      end
      ST_YY: begin
        ctrl_o.mul_sel = MUL_YY;
        ctrl_o.ld_sqx  = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        ctrl_o.ld_sqy = 1'b1;
        state_d = (stat_i.esc_sum || stat_i.cnt_at_max) ? ST_DONE : ST_XY;
      end
      ST_DONE: begin
        // Hold the count until the output word is free
        if (stat_i.out_free) begin
          ctrl_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/mbet_checker.sv
`default_nettype none

module mbet_checker
  import mbet_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  pix_valid_i,
  input wire logic                  pix_ready_i,
  input wire logic                  res_valid_i,
  input wire logic                  res_ready_i,
  input wire logic [COUNT_BITS-1:0] res_count_i,
  input wire logic [SHADE_W-1:0]    res_shade_i
);

  // Keep a stalled result word offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result word dropped while stalled");

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_count_i) && $stable(res_shade_i))
    else $error("result word changed while stalled");

  // Shade follows the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_shade_i == SHADE_W'(res_count_i << SHADE_SHIFT))
    else $error("gray shade does not match iteration count");

  // One pixel at a time: ready drops after a pixel is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_ready_i |=> !pix_ready_i)
    else $error("pixel taken while another is in flight");

endmodule

bind mandelbrot_escape_time_pixel_unit mbet_checker u_mbet_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_i.valid),
  .pix_ready_i (pix_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_count_i (res_o.iteration_count),
  .res_shade_i (res_o.gray_shade)
);

`default_nettype wire

// File: bench/mandelbrot_escape_time_pixel_unit_tb.sv
`timescale 1ns / 100ps

module mandelbrot_escape_time_pixel_unit_tb;
  import mbet_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 600;
  localparam int unsigned QUIET_TAIL    = 80;
  localparam int unsigned DIR_ROWS      = 51;
  localparam int unsigned RUN_LIMIT_NS  = 50_000_000;

  localparam logic signed [63:0] COORD_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] COORD_MIN = -64'sh0000_0000_8000_0000;

  // Indexes past the last register: writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(REG_MAX_ITER) + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [SHADE_W-1:0]    shade;
  } escape_t;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
    logic [PIX_W-1:0]      col;
    logic [PIX_W-1:0]      row;
    logic                  typed;
    escape_t               known;
  } dir_row_t;

  typedef enum logic [1:0] {VIEW_NEAR_SET, VIEW_DEFAULT, VIEW_WILD, VIEW_EXTREME} view_kind_e;

  logic clk = 1'b0;
  logic rst_n;

  mbet_pix_if pix_if ();
  mbet_res_if res_if ();
  mbet_cfg_if cfg_if ();

  mandelbrot_escape_time_pixel_unit u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Viewport and bound as the block should hold them
  logic signed [COORD_W-1:0] view_left  = LEFT_RST;
  logic signed [COORD_W-1:0] view_top   = TOP_RST;
  logic [STEP_W-1:0]         step_x     = CSTEP_RST;
  logic [STEP_W-1:0]         step_y     = RSTEP_RST;
  logic [MAXIT_W-1:0]        iter_limit = MAXIT_RST;

  escape_t  expected_escapes [$];
  dir_row_t directed_rows [DIR_ROWS];

  bit idle_on  = 1'b1;
  bit stall_on = 1'b1;
  int mismatch_count  = 0;
  int results_checked = 0;
  int deepest_count   = 0;
  int directed_pixels = 0;
  int random_pixels   = 0;
  int view_settings   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pull a mapped coordinate back into the signed Q8.24 range
  function automatic logic signed [63:0] clip_coord(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > COORD_MAX) begin
      c = COORD_MAX;
    end else if (v < COORD_MIN) begin
      c = COORD_MIN;
    end
    return c;
  endfunction

  // Escape-time count of one pixel under the current viewport, exact arithmetic
  function automatic escape_t predict_escape(input logic [PIX_W-1:0] col,
                                             input logic [PIX_W-1:0] row);
    logic [PIX_W-1:0]    pc;
    logic [PIX_W-1:0]    pr;
    logic signed [63:0]  re_raw;
    logic signed [63:0]  im_raw;
    logic signed [127:0] cx;
    logic signed [127:0] cy;
    logic signed [127:0] x;
    logic signed [127:0] y;
    logic signed [127:0] nx;
    logic signed [127:0] ny;
    logic signed [127:0] lim;
    logic signed [127:0] thr;
    logic [MAXIT_W:0]    n;
    escape_t             r;
    pc = col;
    pr = row;
    if (32'(pc) >= MAX_PIXELS) pc = PIX_W'(MAX_PIXELS - 1);
    if (32'(pr) >= MAX_PIXELS) pr = PIX_W'(MAX_PIXELS - 1);
    re_raw = {{32{view_left[COORD_W-1]}}, view_left} + 64'(pc) * 64'(step_x);
    im_raw = {{32{view_top[COORD_W-1]}}, view_top} - 64'(pr) * 64'(step_y);
    cx  = clip_coord(re_raw);
    cy  = clip_coord(im_raw);
    lim = 128'(ESC_RADIUS) << FRAC_BITS;
    thr = 128'(ESC_RADIUS * ESC_RADIUS) << (2 * FRAC_BITS);
    x = '0;
    y = '0;
    n = '0;
    // Count first, update z, then test; shifts floor toward minus infinity
    while (n < {1'b0, iter_limit}) begin
      n  = n + (MAXIT_W + 1)'(1);
      nx = ((x * x - y * y) >>> FRAC_BITS) + cx;
      ny = (((x * y) <<< 1) >>> FRAC_BITS) + cy;
      x  = nx;
      y  = ny;
      if (x > lim || x < -lim || y > lim || y < -lim) break;
      if (x * x + y * y > thr) break;
    end
    r.count = COUNT_BITS'(n);
    r.shade = SHADE_W'(n << SHADE_SHIFT);
    return r;
  endfunction

  function automatic dir_row_t wr_row(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.reg_index = idx;
    r.wdata = data;
    return r;
  endfunction

  function automatic dir_row_t px_row(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    dir_row_t r;
    r = '0;
    r.kind = ROW_PIXEL;
    r.col = col;
    r.row = row;
    return r;
  endfunction

  function automatic dir_row_t px_known(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
                                        input logic [COUNT_BITS-1:0] count,
                                        input logic [SHADE_W-1:0] shade);
    dir_row_t r;
    r = px_row(col, row);
    r.typed = 1'b1;
    r.known.count = count;
    r.known.shade = shade;
    return r;
  endfunction

  // Offer one pixel word, maybe after a short gap; valid stays up afterwards
  task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
                            input logic typed, input escape_t known);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      pix_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.valid        = 1'b1;
    pix_if.pixel_column = col;
    pix_if.pixel_row    = row;
    do @(posedge clk); while (!pix_if.ready);
    expected_escapes.push_back(typed ? known : predict_escape(col, row));
  endtask

  // Drop valid and wait for every owed result
  task automatic hold_until_idle();
    @(negedge clk);
    pix_if.valid = 1'b0;
    while (expected_escapes.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid     = 1'b1;
    cfg_if.reg_index = idx;
    cfg_if.wdata     = data;
    do @(posedge clk); while (!cfg_if.ready);
    case (cfg_reg_e'(idx))
      REG_LEFT_EDGE:   view_left  = data;
      REG_TOP_EDGE:    view_top   = data;
      REG_COLUMN_STEP: step_x     = data[STEP_W-1:0];
      REG_ROW_STEP:    step_y     = data[STEP_W-1:0];
      REG_MAX_ITER:    iter_limit = data[MAXIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_edge();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 2))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_step();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 2))
      0:       v = '0;
      1:       v = 32'h7FFF_FFFF;
      default: v = 32'd1;
    endcase
    return v;
  endfunction

  // Load a fresh viewport and bound for the next batch of pixels
  task automatic program_view();
    view_kind_e kind;
    int         sel;
    sel = $urandom_range(0, 9);
    kind = (sel < 6) ? VIEW_NEAR_SET : (sel == 6) ? VIEW_DEFAULT :
           (sel < 9) ? VIEW_WILD : VIEW_EXTREME;
    case (kind)
      VIEW_NEAR_SET: begin
        write_register(REG_LEFT_EDGE, 32'(int'($urandom_range(0, 50331648)) - 41943040));
        write_register(REG_TOP_EDGE, 32'(int'($urandom_range(0, 50331648)) - 25165824));
        write_register(REG_COLUMN_STEP, $urandom_range(64, 4096));
        write_register(REG_ROW_STEP, $urandom_range(64, 4096));
      end
      VIEW_DEFAULT: begin
        write_register(REG_LEFT_EDGE, LEFT_RST);
        write_register(REG_TOP_EDGE, TOP_RST);
        write_register(REG_COLUMN_STEP, 32'(CSTEP_RST));
        write_register(REG_ROW_STEP, 32'(RSTEP_RST));
      end
      VIEW_WILD: begin
        write_register(REG_LEFT_EDGE, $urandom);
        write_register(REG_TOP_EDGE, $urandom);
        write_register(REG_COLUMN_STEP, $urandom);
        write_register(REG_ROW_STEP, $urandom);
      end
      default: begin
        write_register(REG_LEFT_EDGE, pick_edge());
        write_register(REG_TOP_EDGE, pick_edge());
        write_register(REG_COLUMN_STEP, pick_step());
        write_register(REG_ROW_STEP, pick_step());
      end
    endcase
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      write_register(REG_MAX_ITER, '0);
    end else if (sel < 8) begin
      write_register(REG_MAX_ITER, $urandom_range(1, 64));
    end else begin
      write_register(REG_MAX_ITER, $urandom_range(65, 200));
    end
    if ($urandom_range(0, 3) == 0) begin
      write_register(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
    end
    view_settings++;
  endtask

  // Result side: random stall bursts while allowed
  initial begin
    int stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && stall_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  // Compare every accepted result word with the oldest expectation
  always @(posedge clk) begin : check_results
    escape_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_escapes.size() == 0) begin
        $display("%0t: result with none expected: expected none, got count %0d shade %0d",
                 $time, res_if.iteration_count, res_if.gray_shade);
        mismatch_count++;
      end else begin
        want = expected_escapes.pop_front();
        results_checked++;
        if (int'(want.count) > deepest_count) deepest_count = int'(want.count);
        if (res_if.iteration_count !== want.count) begin
          $display("%0t: iteration_count expected %0d, got %0d",
                   $time, want.count, res_if.iteration_count);
          mismatch_count++;
        end
        if (res_if.gray_shade !== want.shade) begin
          $display("%0t: gray_shade expected %0d, got %0d",
                   $time, want.shade, res_if.gray_shade);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int phase_len;
    pix_if.valid        = 1'b0;
    pix_if.pixel_column = '0;
    pix_if.pixel_row    = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.reg_index    = REG_LEFT_EDGE;
    cfg_if.wdata        = '0;
    rst_n               = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows: reset view, zero bound, saturation, long loops, ignored writes
    directed_rows = '{
      px_known(0, 0, 3, 12),
      px_row(4095, 4095),
      wr_row(REG_MAX_ITER, 32'd0),
      px_known(0, 0, 0, 0),
      px_known(4095, 4095, 0, 0),
      wr_row(REG_MAX_ITER, 32'd64),
      wr_row(REG_LEFT_EDGE, 32'd0),
      wr_row(REG_TOP_EDGE, 32'd0),
      px_known(0, 0, 64, 0),
      wr_row(REG_COLUMN_STEP, 32'h7FFF_FFFF),
      px_known(4095, 0, 1, 4),
      wr_row(REG_ROW_STEP, 32'h7FFF_FFFF),
      px_known(0, 4095, 1, 4),
      px_known(4095, 4095, 1, 4),
      wr_row(REG_LEFT_EDGE, 32'h8000_0000),
      wr_row(REG_TOP_EDGE, 32'h7FFF_FFFF),
      px_known(0, 0, 1, 4),
      px_known(4095, 4095, 1, 4),
      wr_row(REG_COLUMN_STEP, 32'd0),
      wr_row(REG_ROW_STEP, 32'd0),
      wr_row(REG_LEFT_EDGE, 32'd0),
      wr_row(REG_TOP_EDGE, 32'd0),
      wr_row(REG_MAX_ITER, 32'h0000_FFFF),
      px_known(4095, 4095, 65535, 252),
      wr_row(REG_MAX_ITER, 32'd1),
      px_known(2048, 2048, 1, 4),
      wr_row(REG_MAX_ITER, 32'd255),
      px_known(1, 1, 255, 252),
      wr_row(REG_MAX_ITER, 32'd64),
      wr_row(REG_SPARE_LO, 32'd0),
      wr_row(REG_SPARE_HI, 32'hFFFF_FFFF),
      px_known(0, 0, 64, 0),
      wr_row(REG_LEFT_EDGE, 32'hFF40_0000),
      wr_row(REG_TOP_EDGE, 32'h0019_999A),
      wr_row(REG_COLUMN_STEP, 32'd1024),
      wr_row(REG_ROW_STEP, 32'd1024),
      px_row(0, 0),
      px_row(37, 21),
      px_row(4095, 4095),
      px_row(12'hAAA, 12'h555),
      px_row(12'h555, 12'hAAA),
      wr_row(REG_LEFT_EDGE, 32'h0040_0000),
      wr_row(REG_TOP_EDGE, 32'd0),
      wr_row(REG_COLUMN_STEP, 32'd64),
      px_row(0, 0),
      px_row(1, 0),
      px_row(300, 5),
      wr_row(REG_LEFT_EDGE, 32'hFE00_0000),
      px_row(0, 0),
      wr_row(REG_LEFT_EDGE, 32'(-2071261)),
      px_row(3, 7)
    };

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        hold_until_idle();
        write_register(directed_rows[i].reg_index, directed_rows[i].wdata);
      end else begin
        send_pixel(directed_rows[i].col, directed_rows[i].row,
                   directed_rows[i].typed, directed_rows[i].known);
        directed_pixels++;
      end
    end

    // Random batches, each under its own viewport; quiet handshakes at the tail
    while (random_pixels < RANDOM_PIXELS) begin
      if (random_pixels >= RANDOM_PIXELS - QUIET_TAIL) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      hold_until_idle();
      program_view();
      phase_len = $urandom_range(30, 70);
      repeat (phase_len) begin
        send_pixel(PIX_W'($urandom_range(0, MAX_PIXELS - 1)),
                   PIX_W'($urandom_range(0, MAX_PIXELS - 1)), 1'b0, '0);
        random_pixels++;
      end
    end

    hold_until_idle();
    repeat (20) @(posedge clk);

    $display("Ran %0d directed and %0d random pixel words over %0d random view settings.",
             directed_pixels, random_pixels, view_settings);
    $display("Compared %0d result words; deepest escape count %0d.",
             results_checked, deepest_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
